// ----- sv/bdc_pkg.sv -----
// Shared types, constants and calendar tables for the business day counter.
// Used by bdc_ctrl, bdc_datapath and business_day_counter; depends on nothing.
`default_nettype none

package bdc_pkg;

	localparam int MAX_YEAR = 9999;

	localparam int DAY_W  = 5;
	localparam int MON_W  = 4;
	localparam int YEAR_W = 14;
	localparam int CNT_W  = 22;
	localparam int MASK_W = 7;
	localparam int WD_W   = 3;
	localparam int IN_W   = 48;
	localparam int OUT_W  = 24;

	// A serial day number of any 14-bit year stays below 2**23.
	localparam int SER_W  = 23;
	localparam int Q_W    = 21;
	localparam int TOT_W  = 24;
	localparam int C25_W  = 8;
	localparam int P25_W  = 25;

	localparam logic [MASK_W-1:0] WEEKEND_RESET = 7'd48;
	localparam logic [CNT_W-1:0]  COUNT_MAX     = '1;

	// Division by 25 of values below 4096 by reciprocal multiplication.
	localparam logic [12:0] DIV25_MUL = 13'd5243;
	localparam int          DIV25_SH  = 17;

	// Division by 7 of values below 2**23 by reciprocal multiplication.
	localparam logic [23:0] DIV7_MUL  = 24'd9586981;
	localparam int          DIV7_SH   = 26;
	localparam int          PROD_W    = SER_W + 24;

	typedef struct packed {
		logic [1:0]        pad;
		logic [YEAR_W-1:0] end_year;
		logic [MON_W-1:0]  end_month;
		logic [DAY_W-1:0]  end_day;
		logic [YEAR_W-1:0] start_year;
		logic [MON_W-1:0]  start_month;
		logic [DAY_W-1:0]  start_day;
	} in_item_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_LOAD,
		OP_PREP_S,
		OP_SER_S,
		OP_PREP_E,
		OP_SER_E,
		OP_DIFF,
		OP_W1,
		OP_W2,
		OP_N1,
		OP_N2,
		OP_TOTAL,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_sts_t;

	// Days from March 1 to the first day of a month counted from March.
	function automatic logic [8:0] days_before(input logic [MON_W-1:0] mm);
		logic [8:0] d;
		unique case (mm)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd61;
			4'd3:    d = 9'd92;
			4'd4:    d = 9'd122;
			4'd5:    d = 9'd153;
			4'd6:    d = 9'd184;
			4'd7:    d = 9'd214;
			4'd8:    d = 9'd245;
			4'd9:    d = 9'd275;
			4'd10:   d = 9'd306;
			4'd11:   d = 9'd337;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	// Length of a month; months outside the year have length zero.
	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic leap);
		logic [DAY_W-1:0] n;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
			4'd2:                                       n = leap ? 5'd29 : 5'd28;
			default:                                    n = 5'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// ----- sv/bdc_ctrl.sv -----
// Sequencing state machine for the business day counter.
// Issues one datapath operation per cycle; depends on bdc_pkg.
`default_nettype none

module bdc_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_tvalid,
	output logic              s_tready,
	input  bdc_pkg::dp_sts_t  sts,
	output bdc_pkg::dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP_S,
		S_SER_S,
		S_PREP_E,
		S_SER_E,
		S_DIFF,
		S_W1,
		S_W2,
		S_N1,
		S_N2,
		S_TOTAL,
		S_DONE
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:   if (s_tvalid) state_q <= S_PREP_S;
				S_PREP_S: state_q <= S_SER_S;
				S_SER_S:  state_q <= S_PREP_E;
				S_PREP_E: state_q <= S_SER_E;
				S_SER_E:  state_q <= S_DIFF;
				S_DIFF:   state_q <= S_W1;
				S_W1:     state_q <= S_W2;
				S_W2:     state_q <= S_N1;
				S_N1:     state_q <= S_N2;
				S_N2:     state_q <= S_TOTAL;
				S_TOTAL:  state_q <= S_DONE;
				S_DONE:   if (sts.out_free) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		unique case (state_q)
			S_IDLE:   cmd.op = s_tvalid ? bdc_pkg::OP_LOAD : bdc_pkg::OP_IDLE;
			S_PREP_S: cmd.op = bdc_pkg::OP_PREP_S;
			S_SER_S:  cmd.op = bdc_pkg::OP_SER_S;
			S_PREP_E: cmd.op = bdc_pkg::OP_PREP_E;
			S_SER_E:  cmd.op = bdc_pkg::OP_SER_E;
			S_DIFF:   cmd.op = bdc_pkg::OP_DIFF;
			S_W1:     cmd.op = bdc_pkg::OP_W1;
			S_W2:     cmd.op = bdc_pkg::OP_W2;
			S_N1:     cmd.op = bdc_pkg::OP_N1;
			S_N2:     cmd.op = bdc_pkg::OP_N2;
			S_TOTAL:  cmd.op = bdc_pkg::OP_TOTAL;
			S_DONE:   cmd.op = sts.out_free ? bdc_pkg::OP_OUT : bdc_pkg::OP_IDLE;
			default:  cmd.op = bdc_pkg::OP_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ----- sv/bdc_datapath.sv -----
// Datapath of the business day counter: date check, serial day numbers,
// divide-by-seven unit, weekly count and output register. Depends on bdc_pkg.
`default_nettype none

module bdc_datapath (
	input  wire                          clk,
	input  wire                          arst_n,
	input  bdc_pkg::in_item_t            in_item,
	input  bdc_pkg::dp_cmd_t             cmd,
	output bdc_pkg::dp_sts_t             sts,
	input  wire                          cfg_valid,
	input  wire [bdc_pkg::MASK_W-1:0]    cfg_data,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [bdc_pkg::OUT_W-1:0]    m_tdata,
	output logic                         m_tuser
);

	bdc_pkg::in_item_t                 item_q;
	logic [bdc_pkg::C25_W-1:0]         c100_q, c400_q, yq_q;
	logic [bdc_pkg::SER_W-1:0]         ser_s_q, ser_e_q, n_q, x_q;
	logic                              ok_s_q, ok_e_q, err_q, err_out_q;
	logic [bdc_pkg::PROD_W-1:0]        prod_q;
	logic [bdc_pkg::WD_W-1:0]          w0_q, r_q;
	logic [bdc_pkg::Q_W-1:0]           q_q;
	logic [bdc_pkg::TOT_W-1:0]         total_q;
	logic [bdc_pkg::CNT_W-1:0]         cnt_q;
	logic [bdc_pkg::MASK_W-1:0]        mask_q;
	logic                              m_tvalid_q;

	logic                              use_end, early, leap, div100, date_ok;
	logic [bdc_pkg::DAY_W-1:0]         cur_d, mlen;
	logic [bdc_pkg::MON_W-1:0]         cur_m, mm;
	logic [bdc_pkg::YEAR_W-1:0]        cur_y, yy;
	logic [bdc_pkg::P25_W-1:0]         p100, p400, py;
	logic [bdc_pkg::SER_W-1:0]         ser_d, x_d, rdiff;
	logic [bdc_pkg::PROD_W-1:0]        prod_d;
	logic [bdc_pkg::Q_W-1:0]           q_cur;
	logic [bdc_pkg::WD_W-1:0]          per_week, left;
	logic [3:0]                        idx;
	logic [bdc_pkg::TOT_W-1:0]         total_d;
	logic [bdc_pkg::CNT_W-1:0]         sat_cnt;

	// One calendar unit serves both dates in turn.
	assign use_end = (cmd.op == bdc_pkg::OP_PREP_E) || (cmd.op == bdc_pkg::OP_SER_E);
	assign cur_d   = use_end ? item_q.end_day   : item_q.start_day;
	assign cur_m   = use_end ? item_q.end_month : item_q.start_month;
	assign cur_y   = use_end ? item_q.end_year  : item_q.start_year;

	// January and February count as months of the previous year.
	assign early = (cur_m < 4'd3);
	assign yy    = cur_y - bdc_pkg::YEAR_W'(early);
	assign mm    = early ? cur_m + 4'd9 : cur_m - 4'd3;

	assign p100 = bdc_pkg::P25_W'(yy[bdc_pkg::YEAR_W-1:2]) * bdc_pkg::P25_W'(bdc_pkg::DIV25_MUL);
	assign p400 = bdc_pkg::P25_W'(yy[bdc_pkg::YEAR_W-1:4]) * bdc_pkg::P25_W'(bdc_pkg::DIV25_MUL);
	assign py   = bdc_pkg::P25_W'(cur_y[bdc_pkg::YEAR_W-1:2]) *
	              bdc_pkg::P25_W'(bdc_pkg::DIV25_MUL);

	assign ser_d = bdc_pkg::SER_W'(cur_d)
	             + bdc_pkg::SER_W'(bdc_pkg::days_before(mm))
	             + bdc_pkg::SER_W'(yy) * bdc_pkg::SER_W'(365)
	             + bdc_pkg::SER_W'(yy[bdc_pkg::YEAR_W-1:2])
	             - bdc_pkg::SER_W'(c100_q)
	             + bdc_pkg::SER_W'(c400_q);

	// A year divisible by four is a century year when its quarter is a multiple
	// of 25, and then a leap year only when the century count is a multiple of 4.
	assign div100  = ((12'(yq_q) * 12'd25) == cur_y[bdc_pkg::YEAR_W-1:2]);
	assign leap    = (cur_y[1:0] == 2'd0) && (!div100 || (yq_q[1:0] == 2'd0));
	assign mlen    = bdc_pkg::month_len(cur_m, leap);
	assign date_ok = (cur_y != '0) && (32'(cur_y) <= bdc_pkg::MAX_YEAR) &&
	                 (cur_m >= 4'd1) && (cur_m <= 4'd12) &&
	                 (cur_d != '0) && (cur_d <= mlen);

	// Divide-by-seven unit: multiply now, fix the remainder in the next cycle.
	assign x_d    = (cmd.op == bdc_pkg::OP_W1) ? ser_s_q + bdc_pkg::SER_W'(2) : n_q;
	assign prod_d = bdc_pkg::PROD_W'(x_d) * bdc_pkg::PROD_W'(bdc_pkg::DIV7_MUL);
	assign q_cur  = prod_q[bdc_pkg::DIV7_SH +: bdc_pkg::Q_W];
	assign rdiff  = x_q - bdc_pkg::SER_W'(q_cur) * bdc_pkg::SER_W'(7);

	assign per_week = bdc_pkg::WD_W'($countones(~mask_q));

	// Leftover days start at the first weekday of the range.
	always_comb begin
		left = '0;
		idx  = '0;
		for (int i = 0; i < 7; i++) begin
			idx = 4'(w0_q) + 4'(i);
			if (idx >= 4'd7)
				idx = idx - 4'd7;
			if ((3'(i) < r_q) && !mask_q[idx[2:0]])
				left = left + 3'd1;
		end
	end

	assign total_d = bdc_pkg::TOT_W'(q_q) * bdc_pkg::TOT_W'(per_week) + bdc_pkg::TOT_W'(left);
	assign sat_cnt = (total_q > bdc_pkg::TOT_W'(bdc_pkg::COUNT_MAX)) ?
	                 bdc_pkg::COUNT_MAX : total_q[bdc_pkg::CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q     <= bdc_pkg::WEEKEND_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid)
				mask_q <= cfg_data;
			if (cmd.op == bdc_pkg::OP_OUT)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			bdc_pkg::OP_LOAD: item_q <= in_item;
			bdc_pkg::OP_PREP_S, bdc_pkg::OP_PREP_E: begin
				c100_q <= p100[bdc_pkg::DIV25_SH +: bdc_pkg::C25_W];
				c400_q <= p400[bdc_pkg::DIV25_SH +: bdc_pkg::C25_W];
				yq_q   <= py[bdc_pkg::DIV25_SH +: bdc_pkg::C25_W];
			end
			bdc_pkg::OP_SER_S: begin
				ser_s_q <= ser_d;
				ok_s_q  <= date_ok;
			end
			bdc_pkg::OP_SER_E: begin
				ser_e_q <= ser_d;
				ok_e_q  <= date_ok;
			end
			bdc_pkg::OP_DIFF: begin
				err_q <= !(ok_s_q && ok_e_q);
				if (ok_s_q && ok_e_q && (ser_s_q < ser_e_q))
					n_q <= ser_e_q - ser_s_q;
				else
					n_q <= '0;
			end
			bdc_pkg::OP_W1, bdc_pkg::OP_N1: begin
				x_q    <= x_d;
				prod_q <= prod_d;
			end
			bdc_pkg::OP_W2: w0_q <= rdiff[bdc_pkg::WD_W-1:0];
			bdc_pkg::OP_N2: begin
				q_q <= q_cur;
				r_q <= rdiff[bdc_pkg::WD_W-1:0];
			end
			bdc_pkg::OP_TOTAL: total_q <= total_d;
			bdc_pkg::OP_OUT: begin
				cnt_q     <= err_q ? '0 : sat_cnt;
				err_out_q <= err_q;
			end
			default: ;
		endcase
	end

	assign sts.out_free = !m_tvalid_q || m_tready;
	assign m_tvalid     = m_tvalid_q;
	assign m_tdata      = {{(bdc_pkg::OUT_W - bdc_pkg::CNT_W){1'b0}}, cnt_q};
	assign m_tuser      = err_out_q;

endmodule

`default_nettype wire

// ----- sv/business_day_counter.sv -----
// Top level of the business day counter: stream ports and weekend mask port.
// Instantiates bdc_ctrl and bdc_datapath; depends on bdc_pkg.
//
// Usage: a request on the s_t* channel carries a start and an end date. The
// block answers each request with one item on the m_t* channel: the count of
// days in [start, end) whose weekday is not set in the weekend mask, with
// m_tuser high (and a count of zero) when either date is not a valid
// Gregorian date within the supported years.
// The weekend mask is written through cfg_valid/cfg_data; cfg_ready is always
// high. Write it only while no request is in flight.
// Sequence: a taken request passes the calendar steps for the start and end
// dates, the difference, the weekday and week-count divisions by seven, the
// total and the output step, run by the controller through the one shared
// serial-day unit and the one divide-by-seven unit; a new request waits for the output step.
// Reset clears the output valid and loads the mask with Thursday and Friday.
// A result waits in the output register while m_tready is low; the next
// request is then taken but held at its last step until the register frees.
`default_nettype none

module business_day_counter (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        s_tvalid,
	output logic                       s_tready,
	// start_day[4:0], start_month[8:5], start_year[22:9], end_day[27:23],
	// end_month[31:28], end_year[45:32], zero padding[47:46]
	input  wire [bdc_pkg::IN_W-1:0]    s_tdata,
	output logic                       m_tvalid,
	input  wire                        m_tready,
	// business_days[21:0], zero padding[23:22]
	output logic [bdc_pkg::OUT_W-1:0]  m_tdata,
	// status[0]: high for an invalid date
	output logic                       m_tuser,
	input  wire                        cfg_valid,
	output logic                       cfg_ready,
	input  wire [bdc_pkg::MASK_W-1:0]  cfg_data
);

	bdc_pkg::dp_cmd_t  cmd;
	bdc_pkg::dp_sts_t  sts;
	bdc_pkg::in_item_t in_item;

	assign in_item   = bdc_pkg::in_item_t'(s_tdata);
	assign cfg_ready = 1'b1;

	bdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bdc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

`default_nettype wire

// ----- sv/bdc_checker.sv -----
// Port-level assertions for the business day counter and the bind that
// attaches them to the top level. Depends on business_day_counter's ports.
`default_nettype none

module bdc_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [23:0] m_tdata,
	input wire        m_tuser
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Only one request is worked on at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// An invalid date reports a zero count.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[21:0] == 22'd0)
		else $error("nonzero count with error status");

	// Padding bits above the count stay zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:22] == 2'd0)
		else $error("padding bits set");

endmodule

bind business_day_counter bdc_checker u_bdc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// ----- tb/sv/tb_business_day_counter.sv -----
`timescale 1ns / 100ps
// Testbench for business_day_counter: sends start/end date requests, predicts each
// business day count and status in its own calendar code, and checks every result.
// Depends on bdc_pkg and the business_day_counter RTL only.

module tb_business_day_counter;

	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 30;
	localparam int MAX_REPORTS   = 10;

	localparam logic [bdc_pkg::MASK_W-1:0] MASK_NONE    = '0;
	localparam logic [bdc_pkg::MASK_W-1:0] MASK_ALL     = '1;
	localparam logic [bdc_pkg::MASK_W-1:0] MASK_SAT_SUN = 7'b1000001;

	typedef struct packed {
		logic [bdc_pkg::CNT_W-1:0] days;
		logic                      bad;
	} day_count_t;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       s_tvalid  = 1'b0;
	logic                       s_tready;
	logic [bdc_pkg::IN_W-1:0]   s_tdata   = '0;
	logic                       m_tvalid;
	logic                       m_tready  = 1'b0;
	logic [bdc_pkg::OUT_W-1:0]  m_tdata;
	logic                       m_tuser;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [bdc_pkg::MASK_W-1:0] cfg_data  = '0;

	day_count_t                 expected_counts[$];
	logic [bdc_pkg::MASK_W-1:0] weekend_days      = bdc_pkg::WEEKEND_RESET;
	int                         sender_idle_pct   = 0;
	int                         receiver_idle_pct = 0;
	int                         items_sent        = 0;
	int                         invalid_sent      = 0;
	int                         results_checked   = 0;
	int                         mismatch_count    = 0;
	int                         masks_used        = 1;

	business_day_counter u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------- calendar

	function automatic bit leap_year(input int y);
		return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
	endfunction

	function automatic int month_days(input int m, input int y);
		int n;
		case (m)
			2:           n = leap_year(y) ? 29 : 28;
			4, 6, 9, 11: n = 30;
			default:     n = (m >= 1 && m <= 12) ? 31 : 0;
		endcase
		return n;
	endfunction

	function automatic bit date_valid(input int d, input int m, input int y);
		return y >= 1 && y <= bdc_pkg::MAX_YEAR && d >= 1 && d <= month_days(m, y);
	endfunction

	// Years start in March here, so January and February belong to the year before.
	function automatic int day_number(input int d, input int m, input int y);
		int yr, mo;
		yr = (m <= 2) ? y - 1 : y;
		mo = (m <= 2) ? m + 9 : m - 3;
		return d + (153 * mo + 2) / 5 + 365 * yr + yr / 4 - yr / 100 + yr / 400;
	endfunction

	// Zero is Sunday.
	function automatic int week_day(input int d, input int m, input int y);
		int yr, mo;
		yr = (m <= 2) ? y - 1 : y;
		mo = (m <= 2) ? m + 10 : m - 2;
		return (d + yr + yr / 4 - yr / 100 + yr / 400 + (31 * mo) / 12) % 7;
	endfunction

	function automatic day_count_t predict_business_days(input bdc_pkg::in_item_t r,
			input logic [bdc_pkg::MASK_W-1:0] mask);
		day_count_t res;
		int first, stop, span, dow, workdays, total;
		res = '0;
		if (!date_valid(r.start_day, r.start_month, r.start_year) ||
				!date_valid(r.end_day, r.end_month, r.end_year)) begin
			res.bad = 1'b1;
		end else begin
			first = day_number(r.start_day, r.start_month, r.start_year);
			stop  = day_number(r.end_day, r.end_month, r.end_year);
			if (first < stop) begin
				span     = stop - first;
				dow      = week_day(r.start_day, r.start_month, r.start_year);
				workdays = 0;
				for (int i = 0; i < 7; i++)
					if (!mask[i]) workdays++;
				total = (span / 7) * workdays;
				for (int i = 0; i < span % 7; i++)
					if (!mask[(dow + i) % 7]) total++;
				res.days = (total > int'(bdc_pkg::COUNT_MAX)) ?
				           bdc_pkg::COUNT_MAX : bdc_pkg::CNT_W'(total);
			end
		end
		return res;
	endfunction

	function automatic bdc_pkg::in_item_t range_item(input int sd, input int sm, input int sy,
			input int ed, input int em, input int ey);
		bdc_pkg::in_item_t r;
		r             = '0;
		r.start_day   = bdc_pkg::DAY_W'(sd);
		r.start_month = bdc_pkg::MON_W'(sm);
		r.start_year  = bdc_pkg::YEAR_W'(sy);
		r.end_day     = bdc_pkg::DAY_W'(ed);
		r.end_month   = bdc_pkg::MON_W'(em);
		r.end_year    = bdc_pkg::YEAR_W'(ey);
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus

	task automatic send_range(input bdc_pkg::in_item_t r);
		day_count_t want;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= r;
		do @(posedge clk); while (!s_tready);
		want = predict_business_days(r, weekend_days);
		expected_counts.push_back(want);
		items_sent++;
		if (want.bad) invalid_sent++;
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (expected_counts.size() != 0) @(posedge clk);
	endtask

	task automatic write_weekend_mask(input logic [bdc_pkg::MASK_W-1:0] mask);
		wait_for_results();
		cfg_valid <= 1'b1;
		cfg_data  <= mask;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		weekend_days = mask;
		masks_used++;
	endtask

	task automatic pick_date(input int ylo, input int yhi, output int d, output int m,
			output int y);
		y = $urandom_range(ylo, yhi);
		m = $urandom_range(1, 12);
		d = $urandom_range(1, month_days(m, y));
	endtask

	task automatic random_range(output bdc_pkg::in_item_t r);
		int sd, sm, sy, ed, em, ey, kind;
		kind = $urandom_range(0, 99);
		pick_date(1, bdc_pkg::MAX_YEAR, sd, sm, sy);
		pick_date(1, bdc_pkg::MAX_YEAR, ed, em, ey);
		if (kind < 45) begin
			// Typical leave request: the end falls in the same month or up to two later.
			ey = sy;
			em = sm + $urandom_range(0, 2);
			if (em > 12) begin
				if (sy < bdc_pkg::MAX_YEAR) begin
					ey = sy + 1;
					em = em - 12;
				end else begin
					em = 12;
				end
			end
			ed = $urandom_range(1, month_days(em, ey));
		end else if (kind < 52) begin
			pick_date(1, 3, sd, sm, sy);
			pick_date(bdc_pkg::MAX_YEAR - 2, bdc_pkg::MAX_YEAR, ed, em, ey);
		end else if (kind < 60) begin
			ed = sd;
			em = sm;
			ey = sy;
		end else if (kind < 72) begin
			// Around the end of February in leap candidates, centuries included.
			sy = (kind < 66) ? 4 * $urandom_range(1, bdc_pkg::MAX_YEAR / 4) :
			                   100 * $urandom_range(1, 99);
			sm = 2;
			sd = $urandom_range(27, 30);
			ey = sy + $urandom_range(0, 1);
			em = $urandom_range(2, 3);
			ed = $urandom_range(1, 30);
		end else if (kind < 86) begin
			// Keep the two independent dates: long spans in either order.
		end else if (kind < 93) begin
			sd = $urandom_range(0, 31);
			sm = $urandom_range(0, 15);
			sy = $urandom_range(0, 16383);
		end else begin
			ed = $urandom_range(0, 31);
			em = $urandom_range(0, 15);
			ey = $urandom_range(0, 16383);
		end
		r = range_item(sd, sm, sy, ed, em, ey);
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_directed_ranges();
		send_range(range_item(1, 1, 1, 1, 1, 1));
		send_range(range_item(1, 1, 1, 31, 12, 9999));
		send_range(range_item(31, 12, 9999, 1, 1, 1));
		send_range(range_item(0, 1, 2000, 1, 2, 2000));
		send_range(range_item(31, 4, 2021, 1, 5, 2021));
		send_range(range_item(15, 0, 2020, 1, 1, 2021));
		send_range(range_item(15, 13, 2020, 1, 1, 2021));
		send_range(range_item(15, 15, 2020, 1, 1, 2021));
		send_range(range_item(1, 1, 0, 1, 1, 1));
		send_range(range_item(1, 1, 2020, 1, 1, 10000));
		send_range(range_item(1, 1, 2020, 31, 12, 16383));
		send_range(range_item(29, 2, 2024, 1, 3, 2024));
		send_range(range_item(29, 2, 1900, 1, 3, 1900));
		send_range(range_item(29, 2, 2000, 1, 3, 2000));
		send_range(range_item(1, 3, 2023, 29, 2, 2023));
		send_range(range_item(6, 6, 2024, 7, 6, 2024));
		send_range(range_item(1, 7, 2024, 1, 8, 2024));
		send_range(range_item(31, 12, 2023, 1, 1, 2024));
		send_range(range_item(31, 1, 9999, 31, 12, 9999));
		send_range(range_item(0, 0, 0, 0, 0, 0));
		send_range(range_item(31, 15, 16383, 31, 15, 16383));
	endtask

	// With no weekend every day counts; with every weekday masked nothing does.
	task automatic test_mask_extremes();
		write_weekend_mask(MASK_NONE);
		send_range(range_item(1, 1, 1, 31, 12, 9999));
		send_range(range_item(3, 3, 2025, 13, 3, 2025));
		write_weekend_mask(MASK_ALL);
		send_range(range_item(1, 1, 1, 31, 12, 9999));
		send_range(range_item(3, 3, 2025, 13, 3, 2025));
	endtask

	task automatic test_random_ranges(input int count,
			input logic [bdc_pkg::MASK_W-1:0] mask, input int src_pct, input int dst_pct);
		bdc_pkg::in_item_t r;
		write_weekend_mask(mask);
		sender_idle_pct   = src_pct;
		receiver_idle_pct = dst_pct;
		for (int k = 0; k < count; k++) begin
			// Halfway through, hold off until every outstanding request is answered.
			if (k == count / 2) wait_for_results();
			random_range(r);
			send_range(r);
		end
	endtask

	// ---------------------------------------------------------------- checking

	task automatic note_mismatch(input string what, input day_count_t want,
			input day_count_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("Mismatch at %0t: %s: expected count %0d status %0d, %s %0d status %0d",
				$realtime, what, want.days, want.bad, "got count", got.days, got.bad);
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
	end

	always @(posedge clk) begin : check_results
		day_count_t want, got;
		got.days = m_tdata[bdc_pkg::CNT_W-1:0];
		got.bad  = m_tuser;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_counts.size() == 0) begin
				note_mismatch("result with no request outstanding", '0, got);
			end else begin
				want = expected_counts.pop_front();
				results_checked++;
				if (m_tdata != bdc_pkg::OUT_W'(want.days) || m_tuser != want.bad)
					note_mismatch("wrong result", want, got);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no transfer on any channel for %0d cycles", STALL_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		sender_idle_pct   = 29;
		receiver_idle_pct = 55;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_ranges();
		test_mask_extremes();
		test_random_ranges(350, bdc_pkg::MASK_W'($urandom_range(1, 126)), 29, 55);
		test_random_ranges(350, MASK_SAT_SUN, 55, 29);
		test_random_ranges(350, bdc_pkg::MASK_W'($urandom_range(1, 126)), 0, 0);

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d date ranges (%0d with an invalid date) under %0d %s",
			items_sent, invalid_sent, masks_used, "weekend masks,");
		$display("with both sides stalling in turn; %0d results compared, %0d mismatches.",
			results_checked, mismatch_count);
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
sv/bdc_pkg.sv
sv/bdc_ctrl.sv
sv/bdc_datapath.sv
sv/business_day_counter.sv
sv/bdc_checker.sv
tb/sv/tb_business_day_counter.sv
